[rtl/bpc_pkg.sv]
package bpc_pkg;

    localparam logic [7:0] READY_MASK = 8'h60;

    localparam logic [1:0] OUT_OK        = 2'd0;
    localparam logic [1:0] OUT_NOT_READY = 2'd1;
    localparam logic [1:0] OUT_RAW_ZERO  = 2'd2;
    localparam logic [1:0] OUT_RANGE     = 2'd3;

    localparam logic [2:0] CFG_CALIB_LOW  = 3'd0;
    localparam logic [2:0] CFG_CALIB_MID  = 3'd1;
    localparam logic [2:0] CFG_CALIB_HIGH = 3'd2;
    localparam logic [2:0] CFG_FLOOR      = 3'd3;
    localparam logic [2:0] CFG_CEILING    = 3'd4;

    localparam logic [16:0] FLOOR_RESET   = 17'd30000;
    localparam logic [16:0] CEILING_RESET = 17'd120000;

    localparam logic [22:0] Q6_MAX = 23'h7FFFFF;

    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } coef_t;

    typedef struct packed {
        logic        not_ready;
        logic        raw_zero;
        logic [23:0] p;
    } side_t;

    // byte i of the calibration image sits at bits 8i+7..8i
    function automatic coef_t decode_coef(input logic [167:0] img);
        coef_t c;
        c.t1  = img[15:0];
        c.t2  = img[31:16];
        c.t3  = img[39:32];
        c.p1  = img[55:40];
        c.p2  = img[71:56];
        c.p3  = img[79:72];
        c.p4  = img[87:80];
        c.p5  = img[103:88];
        c.p6  = img[119:104];
        c.p7  = img[127:120];
        c.p8  = img[135:128];
        c.p9  = img[151:136];
        c.p10 = img[159:152];
        c.p11 = img[167:160];
        return c;
    endfunction

endpackage

[rtl/bpc_temp.sv]
module bpc_temp (
    input  logic                 aclk,
    input  logic [3:0]           en,
    input  bpc_pkg::coef_t       coef,
    input  logic [23:0]          raw_temperature,
    output logic signed [27:0]   t_lin,
    output logic signed [15:0]   temp_q8
);
    import bpc_pkg::*;

    logic signed [24:0] d_reg, d_next;
    logic signed [41:0] dt_reg, dt_next;
    logic signed [49:0] dd_reg, dd_next;
    logic signed [63:0] n_reg, n_next;
    logic signed [27:0] t_reg, t_next;
    logic signed [15:0] tq_reg, tq_next;
    logic signed [63:0] t_wide, tq_wide;

    always_comb begin
        d_next  = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.t1, 8'h00});
        dt_next = d_reg * $signed({1'b0, coef.t2});
        dd_next = d_reg * d_reg;
        n_next  = (64'(dt_reg) <<< 18) + 64'(dd_reg) * 64'(coef.t3);

        // round to Q20 and to 1/256 degC
        t_wide  = (n_reg + 64'sd134217728) >>> 28;
        tq_wide = (n_reg + 64'sd549755813888) >>> 40;
        if (t_wide > 64'sd134217727) begin
            t_next = 28'sh7FFFFFF;
        end else if (t_wide < -64'sd134217728) begin
            t_next = -28'sh8000000;
        end else begin
            t_next = t_wide[27:0];
        end
        if (tq_wide > 64'sd32767) begin
            tq_next = 16'sh7FFF;
        end else if (tq_wide < -64'sd32768) begin
            tq_next = -16'sh8000;
        end else begin
            tq_next = tq_wide[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d_reg <= d_next;
        end
        if (en[1]) begin
            dt_reg <= dt_next;
            dd_reg <= dd_next;
        end
        if (en[2]) begin
            n_reg <= n_next;
        end
        if (en[3]) begin
            t_reg  <= t_next;
            tq_reg <= tq_next;
        end
    end

    assign t_lin   = t_reg;
    assign temp_q8 = tq_reg;

endmodule

[rtl/bpc_tpow.sv]
module bpc_tpow (
    input  logic                 aclk,
    input  logic [4:0]           en,
    input  bpc_pkg::coef_t       coef,
    input  logic signed [27:0]   t_lin,
    output logic signed [47:0]   o1,
    output logic signed [47:0]   q,
    output logic signed [36:0]   r
);
    import bpc_pkg::*;

    logic signed [27:0] t5_reg;
    logic signed [55:0] tt5_reg, tt5_next;
    logic signed [44:0] p6t5_reg, p6t5_next, p2t5_reg, p2t5_next;
    logic signed [35:0] p10t5_reg, p10t5_next;

    logic        [34:0] t2;
    logic signed [46:0] mlo6_reg, mlo6_next;
    logic signed [45:0] mhi6_reg, mhi6_next;
    logic signed [43:0] p7t2_reg, p7t2_next, p3t2_reg, p3t2_next;
    logic signed [44:0] p6t6_reg, p2t6_reg;
    logic signed [36:0] r6_reg, r6_next, r7_reg, r8_reg, r9_reg;

    logic signed [63:0] t2t;
    logic signed [41:0] t3_reg, t3_next;
    logic signed [47:0] o1a_reg, o1a_next, qa_reg, qa_next, o1a8_reg, qa8_reg;

    logic signed [49:0] m8_reg, m8_next, m4_reg, m4_next;
    logic signed [47:0] o1_reg, o1_next, q_reg, q_next;

    logic signed [16:0] p1m, p2m;

    always_comb begin
        p1m = $signed({coef.p1[15], coef.p1}) - 17'sd16384;
        p2m = $signed({coef.p2[15], coef.p2}) - 17'sd16384;

        tt5_next   = t_lin * t_lin;
        p6t5_next  = $signed({1'b0, coef.p6}) * t_lin;
        p2t5_next  = p2m * t_lin;
        p10t5_next = coef.p10 * t_lin;

        // t squared is never negative, so the Q20 value fits unsigned
        t2        = tt5_reg[54:20];
        mlo6_next = $signed({1'b0, t2[17:0]}) * t5_reg;
        mhi6_next = $signed({1'b0, t2[34:18]}) * t5_reg;
        p7t2_next = coef.p7 * $signed({1'b0, t2});
        p3t2_next = coef.p3 * $signed({1'b0, t2});
        r6_next   = (37'(coef.p9) <<< 20) + 37'(p10t5_reg);

        t2t      = (64'(mhi6_reg) <<< 18) + 64'(mlo6_reg);
        t3_next  = t2t[61:20];
        o1a_next = (48'($signed({1'b0, coef.p5})) <<< 23) + 48'(p6t6_reg >>> 6)
                 + 48'(p7t2_reg >>> 8);
        qa_next  = (48'(p1m) <<< 20) + 48'(p2t6_reg >>> 9) + 48'(p3t2_reg >>> 12);

        m8_next = coef.p8 * t3_reg;
        m4_next = coef.p4 * t3_reg;

        o1_next = o1a8_reg + 48'(m8_reg >>> 15);
        q_next  = qa8_reg + 48'(m4_reg >>> 17);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t5_reg    <= t_lin;
            tt5_reg   <= tt5_next;
            p6t5_reg  <= p6t5_next;
            p2t5_reg  <= p2t5_next;
            p10t5_reg <= p10t5_next;
        end
        if (en[1]) begin
            mlo6_reg <= mlo6_next;
            mhi6_reg <= mhi6_next;
            p7t2_reg <= p7t2_next;
            p3t2_reg <= p3t2_next;
            p6t6_reg <= p6t5_reg;
            p2t6_reg <= p2t5_reg;
            r6_reg   <= r6_next;
        end
        if (en[2]) begin
            t3_reg  <= t3_next;
            o1a_reg <= o1a_next;
            qa_reg  <= qa_next;
            r7_reg  <= r6_reg;
        end
        if (en[3]) begin
            m8_reg   <= m8_next;
            m4_reg   <= m4_next;
            o1a8_reg <= o1a_reg;
            qa8_reg  <= qa_reg;
            r8_reg   <= r7_reg;
        end
        if (en[4]) begin
            o1_reg <= o1_next;
            q_reg  <= q_next;
            r9_reg <= r8_reg;
        end
    end

    assign o1 = o1_reg;
    assign q  = q_reg;
    assign r  = r9_reg;

endmodule

[rtl/bpc_press.sv]
module bpc_press (
    input  logic                 aclk,
    input  logic [4:0]           en,
    input  bpc_pkg::coef_t       coef,
    input  logic [23:0]          p,
    input  logic signed [47:0]   o1,
    input  logic signed [47:0]   q,
    input  logic signed [36:0]   r,
    output logic signed [47:0]   pq20
);
    import bpc_pkg::*;

    logic signed [24:0] p25, p11s;
    logic signed [44:0] pqlo_reg, pqlo_next, prlo_reg, prlo_next;
    logic signed [53:0] pqhi_reg, pqhi_next;
    logic signed [42:0] prhi_reg, prhi_next;
    logic        [47:0] pp_reg, pp_next;
    logic        [23:0] p10_reg, p11_reg;
    logic signed [47:0] o1_10_reg, o1_11_reg;

    logic signed [63:0] pqs, prs;
    logic signed [47:0] o2_reg, o2_next;
    logic signed [37:0] pr24_reg, pr24_next;
    logic signed [56:0] ppk_reg, ppk_next;

    logic signed [35:0] a12;
    logic signed [44:0] d1lo_reg, d1lo_next;
    logic signed [43:0] d1hi_reg, d1hi_next, d2lo_reg, d2lo_next;
    logic signed [42:0] d2hi_reg, d2hi_next;
    logic signed [47:0] s12_reg, s12_next, s13_reg;

    logic signed [63:0] d1s, d2s;
    logic signed [39:0] d1_reg, d1_next, d2_reg, d2_next;
    logic signed [47:0] pq20_reg, pq20_next;

    always_comb begin
        p25  = $signed({1'b0, p});
        p11s = $signed({1'b0, p11_reg});

        // wide products split into two partial products
        pqlo_next = $signed({1'b0, q[18:0]}) * p25;
        pqhi_next = $signed(q[47:19]) * p25;
        prlo_next = $signed({1'b0, r[18:0]}) * p25;
        prhi_next = $signed(r[36:19]) * p25;
        pp_next   = p * p;

        pqs       = (64'(pqhi_reg) <<< 19) + 64'(pqlo_reg);
        o2_next   = 48'(pqs >>> 20);
        prs       = (64'(prhi_reg) <<< 19) + 64'(prlo_reg);
        pr24_next = 38'(prs >>> 24);
        ppk_next  = $signed({1'b0, pp_reg}) * coef.p11;

        a12       = 36'(ppk_reg >>> 21);
        d1lo_next = $signed({1'b0, pr24_reg[18:0]}) * p11s;
        d1hi_next = $signed(pr24_reg[37:19]) * p11s;
        d2lo_next = $signed({1'b0, a12[17:0]}) * p11s;
        d2hi_next = $signed(a12[35:18]) * p11s;
        s12_next  = o1_11_reg + o2_reg;

        d1s     = (64'(d1hi_reg) <<< 19) + 64'(d1lo_reg);
        d2s     = (64'(d2hi_reg) <<< 18) + 64'(d2lo_reg);
        d1_next = 40'(d1s >>> 24);
        d2_next = 40'(d2s >>> 24);

        pq20_next = s13_reg + 48'(d1_reg) + 48'(d2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pqlo_reg  <= pqlo_next;
            pqhi_reg  <= pqhi_next;
            prlo_reg  <= prlo_next;
            prhi_reg  <= prhi_next;
            pp_reg    <= pp_next;
            p10_reg   <= p;
            o1_10_reg <= o1;
        end
        if (en[1]) begin
            o2_reg    <= o2_next;
            pr24_reg  <= pr24_next;
            ppk_reg   <= ppk_next;
            p11_reg   <= p10_reg;
            o1_11_reg <= o1_10_reg;
        end
        if (en[2]) begin
            d1lo_reg <= d1lo_next;
            d1hi_reg <= d1hi_next;
            d2lo_reg <= d2lo_next;
            d2hi_reg <= d2hi_next;
            s12_reg  <= s12_next;
        end
        if (en[3]) begin
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
            s13_reg <= s12_reg;
        end
        if (en[4]) begin
            pq20_reg <= pq20_next;
        end
    end

    assign pq20 = pq20_reg;

endmodule

[rtl/baro_pressure_temp_compensation.sv]
// Barometric pressure and temperature compensation.
// Input channel s_*: one request carries the status byte and the raw 24-bit
// pressure and temperature conversions. Result channel m_*: temperature in
// 1/256 degC, pressure in 1/64 Pa, an outcome code and a good flag.
// Configuration channel cfg_*: index 0..2 load the calibration image
// (bytes 0..7, 8..15, 16..20), 3 and 4 the pressure floor and ceiling in Pa;
// other indexes are dropped. cfg_ready is always high. Write it only while
// no request is in flight.
// The datapath is 15 register stages; a request passes through each of them
// in order before m_valid rises. One request per cycle is taken and one
// result per cycle is delivered while m_ready is high.
// Every stage has its own valid bit, so a stalled receiver only holds the
// stages that are full: s_ready stays high unless all 15 stages hold data
// and m_ready is low. Reset empties the pipeline, sets the calibration words
// to zero and the pressure limits to 30000 Pa and 120000 Pa.
module baro_pressure_temp_compensation (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_status_byte,
    input  logic [23:0]         s_raw_pressure,
    input  logic [23:0]         s_raw_temperature,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_temperature_q8,
    output logic [22:0]         m_pressure_q6,
    output logic [1:0]          m_outcome,
    output logic                m_good,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import bpc_pkg::*;

    logic [63:0] calib_low_reg, calib_mid_reg;
    logic [39:0] calib_high_reg;
    logic [16:0] floor_reg, ceiling_reg;
    coef_t       coef;

    logic [15:1] valid_reg, valid_next;
    logic [16:1] ld;

    side_t              side_in;
    side_t              side_reg [1:14];
    logic signed [15:0] tq_reg [5:14];

    logic signed [27:0] t_lin;
    logic signed [15:0] temp_q8;
    logic signed [47:0] o1, q, pq20;
    logic signed [36:0] r;

    logic signed [49:0] q6w;
    logic signed [49:0] floor64, ceil64;
    logic [1:0]         outcome_next;
    logic signed [15:0] tq_next;
    logic [22:0]        q6_next;
    logic               good_next;

    assign coef      = decode_coef({calib_high_reg, calib_mid_reg, calib_low_reg});
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_low_reg  <= '0;
            calib_mid_reg  <= '0;
            calib_high_reg <= '0;
            floor_reg      <= FLOOR_RESET;
            ceiling_reg    <= CEILING_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CALIB_LOW:  calib_low_reg  <= cfg_data;
                CFG_CALIB_MID:  calib_mid_reg  <= cfg_data;
                CFG_CALIB_HIGH: calib_high_reg <= cfg_data[39:0];
                CFG_FLOOR:      floor_reg      <= cfg_data[16:0];
                CFG_CEILING:    ceiling_reg    <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its successor moves on
    always_comb begin
        ld[16] = m_ready;
        for (int k = 15; k >= 1; k--) begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
        valid_next[1] = ld[1] ? s_valid : valid_reg[1];
        for (int k = 2; k <= 15; k++) begin
            valid_next[k] = ld[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = ld[1];
    assign m_valid = valid_reg[15];

    always_comb begin
        side_in.not_ready = (s_status_byte & READY_MASK) != READY_MASK;
        side_in.raw_zero  = (s_raw_pressure == '0) || (s_raw_temperature == '0);
        side_in.p         = s_raw_pressure;
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            side_reg[1] <= side_in;
        end
        for (int k = 2; k <= 14; k++) begin
            if (ld[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (ld[5]) begin
            tq_reg[5] <= temp_q8;
        end
        for (int k = 6; k <= 14; k++) begin
            if (ld[k]) begin
                tq_reg[k] <= tq_reg[k-1];
            end
        end
    end

    bpc_temp u_temp (
        .aclk            (aclk),
        .en              (ld[4:1]),
        .coef            (coef),
        .raw_temperature (s_raw_temperature),
        .t_lin           (t_lin),
        .temp_q8         (temp_q8)
    );

    bpc_tpow u_tpow (
        .aclk  (aclk),
        .en    (ld[9:5]),
        .coef  (coef),
        .t_lin (t_lin),
        .o1    (o1),
        .q     (q),
        .r     (r)
    );

    bpc_press u_press (
        .aclk (aclk),
        .en   (ld[14:10]),
        .coef (coef),
        .p    (side_reg[9].p),
        .o1   (o1),
        .q    (q),
        .r    (r),
        .pq20 (pq20)
    );

    always_comb begin
        q6w     = (50'(pq20) + 50'sd8192) >>> 14;
        floor64 = $signed({27'd0, floor_reg, 6'd0});
        ceil64  = $signed({27'd0, ceiling_reg, 6'd0});
        priority if (side_reg[14].not_ready) begin
            outcome_next = OUT_NOT_READY;
        end else if (side_reg[14].raw_zero) begin
            outcome_next = OUT_RAW_ZERO;
        end else if (q6w < floor64 || q6w > ceil64) begin
            outcome_next = OUT_RANGE;
        end else begin
            outcome_next = OUT_OK;
        end
        if (outcome_next == OUT_NOT_READY || outcome_next == OUT_RAW_ZERO) begin
            tq_next = '0;
            q6_next = '0;
        end else begin
            tq_next = tq_reg[14];
            if (q6w < 50'sd0) begin
                q6_next = '0;
            end else if (q6w > 50'sd8388607) begin
                q6_next = Q6_MAX;
            end else begin
                q6_next = q6w[22:0];
            end
        end
        good_next = outcome_next == OUT_OK;
    end

    always_ff @(posedge aclk) begin
        if (ld[15]) begin
            m_temperature_q8 <= tq_next;
            m_pressure_q6    <= q6_next;
            m_outcome        <= outcome_next;
            m_good           <= good_next;
        end
    end

    a_good_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_good == (m_outcome == OUT_OK)))
        else $error("good flag disagrees with outcome");

    a_rejected_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outcome == OUT_NOT_READY || m_outcome == OUT_RAW_ZERO)
        |-> (m_temperature_q8 == 16'sd0 && m_pressure_q6 == '0))
        else $error("rejected request carries nonzero values");

    a_full_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the pipeline can advance");

endmodule
